@@ hdl/date_interval_calculator_defines.svh @@
// assertion macros for the asserting top-level file
`ifndef DATE_INTERVAL_CALCULATOR_DEFINES_SVH
`define DATE_INTERVAL_CALCULATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DIC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dic_pkg.sv @@
package dic_pkg;

    localparam int CH_W     = 8;
    localparam int DM_W     = 7;
    localparam int YEAR_W   = 14;
    localparam int FC_W     = 3;
    localparam int PH_W     = 3;
    localparam int DIM_W    = 5;
    localparam int STATUS_W = 2;
    localparam int MONTHS_W = 4;
    localparam int DAYS_W   = 6;

    // parse phases
    localparam logic [PH_W-1:0] PH_DAY      = 3'd0;
    localparam logic [PH_W-1:0] PH_DAY_SKIP = 3'd1;
    localparam logic [PH_W-1:0] PH_MON      = 3'd2;
    localparam logic [PH_W-1:0] PH_MON_SKIP = 3'd3;
    localparam logic [PH_W-1:0] PH_YEAR     = 3'd4;
    localparam logic [PH_W-1:0] PH_IGNORE   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INIT_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FINAL_BAD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER     = 2'd3;

    localparam logic [CH_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;

    localparam int MONTHS_PER_YEAR = 12;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;
    localparam int          PROD_W    = YEAR_W + 13;

    localparam logic [DIM_W-1:0] MONTH_DAYS [MONTHS_PER_YEAR] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic              vld;
        logic              which;
        logic [DM_W-1:0]   day;
        logic [DM_W-1:0]   month;
        logic [YEAR_W-1:0] year;
        logic              ok;
    } rec_t;

    typedef struct packed {
        logic              vld;
        logic              which;
        logic [DM_W-1:0]   day;
        logic [DM_W-1:0]   month;
        logic [YEAR_W-1:0] year;
        logic              ok;
        logic [DIM_W-1:0]  prev_dim;
    } chk_t;

    // gregorian leap rule, divide by 100 through a reciprocal
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [7:0]        q;
        logic [YEAR_W-1:0] r;
        prod = PROD_W'(y) * PROD_W'(RECIP_100);
        q    = prod[PROD_W-1:RECIP_SH];
        r    = y - YEAR_W'(q) * YEAR_W'(100);
        return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
    endfunction

    function automatic logic [DIM_W-1:0] days_in_month(input logic [DM_W-1:0] m,
                                                       input logic leap);
        logic [3:0] idx;
        idx = 4'(m - 7'd1);
        if (m == 7'd2)
            return leap ? 5'd29 : 5'd28;
        else if (m < 7'd1 || m > 7'(MONTHS_PER_YEAR))
            return '0;
        else
            return MONTH_DAYS[idx];
    endfunction

endpackage

@@ hdl/dic_in_if.sv @@
interface dic_in_if;
    logic                      valid;
    logic                      ready;
    logic [dic_pkg::CH_W-1:0]  ch;
    logic                      which_date;
    logic                      last;

    modport source (output valid, ch, which_date, last, input ready);
    modport sink   (input valid, ch, which_date, last, output ready);
endinterface

@@ hdl/dic_out_if.sv @@
interface dic_out_if;
    logic                               valid;
    logic                               ready;
    logic [dic_pkg::STATUS_W-1:0]       status;
    logic [dic_pkg::YEAR_W-1:0]         years;
    logic [dic_pkg::MONTHS_W-1:0]       months;
    logic signed [dic_pkg::DAYS_W-1:0]  days;

    modport source (output valid, status, years, months, days, input ready);
    modport sink   (input valid, status, years, months, days, output ready);
endinterface

@@ hdl/dic_parse.sv @@
module dic_parse (
    input  logic          clk,
    input  logic          rst_n,
    dic_in_if.sink        chars,
    input  logic          take,
    output dic_pkg::rec_t rec
);

    logic [dic_pkg::PH_W-1:0]   ph_reg, ph_next;
    logic [dic_pkg::FC_W-1:0]   fc_reg, fc_next;
    logic [dic_pkg::YEAR_W-1:0] fv_reg, fv_next;
    logic                       ended_reg, ended_next;
    logic                       bad_reg, bad_next;
    logic [dic_pkg::DM_W-1:0]   day_reg, day_next;
    logic [dic_pkg::DM_W-1:0]   mon_reg, mon_next;
    dic_pkg::rec_t              rec_reg, rec_next;

    logic                       acc;
    logic                       is_digit;
    logic                       is_slash;
    logic                       take_ch;
    logic                       do_end;
    logic [dic_pkg::FC_W-1:0]   tk_fc;
    logic [dic_pkg::YEAR_W-1:0] fv_x10;
    logic                       ok_parse;

    assign chars.ready = !rec_reg.vld || take;
    assign acc         = chars.valid && chars.ready;
    assign rec         = rec_reg;

    assign is_digit = (chars.ch >= dic_pkg::CHAR_ZERO) && (chars.ch <= dic_pkg::CHAR_NINE);
    assign is_slash = (chars.ch == dic_pkg::CHAR_SLASH);
    assign tk_fc    = fc_reg + 3'd1;
    // x10 as 8x + 2x, wrapped to the field width
    assign fv_x10   = {fv_reg[dic_pkg::YEAR_W-4:0], 3'b000}
                    + {fv_reg[dic_pkg::YEAR_W-2:0], 1'b0};

    always_comb
    begin
        ph_next    = ph_reg;
        fc_next    = fc_reg;
        fv_next    = fv_reg;
        ended_next = ended_reg;
        bad_next   = bad_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        take_ch    = 1'b0;
        do_end     = 1'b0;

        case (ph_reg)
            dic_pkg::PH_DAY, dic_pkg::PH_MON:
            begin
                if (is_slash)
                begin
                    if (fc_reg == '0)
                        bad_next = 1'b1;
                    do_end = 1'b1;
                end
                else
                begin
                    take_ch = 1'b1;
                    if (tk_fc >= 3'd2)
                        ph_next = (ph_reg == dic_pkg::PH_DAY) ? dic_pkg::PH_DAY_SKIP
                                                              : dic_pkg::PH_MON_SKIP;
                end
            end
            dic_pkg::PH_DAY_SKIP, dic_pkg::PH_MON_SKIP:
                do_end = 1'b1;
            dic_pkg::PH_YEAR:
            begin
                take_ch = 1'b1;
                if (tk_fc >= 3'd4)
                    ph_next = dic_pkg::PH_IGNORE;
            end
            default:
                ;
        endcase

        if (take_ch)
        begin
            if (!ended_reg && is_digit)
                fv_next = fv_x10 + {10'd0, chars.ch[3:0]};
            else
                ended_next = 1'b1;
            fc_next = tk_fc;
        end

        if (do_end)
        begin
            if (ph_reg == dic_pkg::PH_DAY || ph_reg == dic_pkg::PH_DAY_SKIP)
            begin
                day_next = fv_reg[dic_pkg::DM_W-1:0];
                ph_next  = dic_pkg::PH_MON;
            end
            else
            begin
                mon_next = fv_reg[dic_pkg::DM_W-1:0];
                ph_next  = dic_pkg::PH_YEAR;
            end
            fc_next    = '0;
            fv_next    = '0;
            ended_next = 1'b0;
        end
    end

    // string must end after two year chars or four and more
    assign ok_parse = !bad_next && ((ph_next == dic_pkg::PH_YEAR && fc_next == 3'd2)
                                    || ph_next == dic_pkg::PH_IGNORE);

    always_comb
    begin
        rec_next = rec_reg;
        if (acc && chars.last)
        begin
            rec_next.vld   = 1'b1;
            rec_next.which = chars.which_date;
            rec_next.day   = day_next;
            rec_next.month = mon_next;
            rec_next.year  = fv_next;
            rec_next.ok    = ok_parse;
        end
        else if (take)
            rec_next.vld = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= dic_pkg::PH_DAY;
            fc_reg    <= '0;
            fv_reg    <= '0;
            ended_reg <= 1'b0;
            bad_reg   <= 1'b0;
            day_reg   <= '0;
            mon_reg   <= '0;
            rec_reg   <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
            if (acc)
            begin
                if (chars.last)
                begin
                    ph_reg    <= dic_pkg::PH_DAY;
                    fc_reg    <= '0;
                    fv_reg    <= '0;
                    ended_reg <= 1'b0;
                    bad_reg   <= 1'b0;
                    day_reg   <= '0;
                    mon_reg   <= '0;
                end
                else
                begin
                    ph_reg    <= ph_next;
                    fc_reg    <= fc_next;
                    fv_reg    <= fv_next;
                    ended_reg <= ended_next;
                    bad_reg   <= bad_next;
                    day_reg   <= day_next;
                    mon_reg   <= mon_next;
                end
            end
        end
    end

endmodule

@@ hdl/dic_check.sv @@
module dic_check (
    input  logic          clk,
    input  logic          rst_n,
    input  dic_pkg::rec_t rec,
    output logic          take,
    input  logic          chk_adv,
    output dic_pkg::chk_t chk
);

    dic_pkg::chk_t            chk_reg, chk_next;
    logic                     leap;
    logic [dic_pkg::DIM_W-1:0] dim;
    logic [dic_pkg::DM_W-1:0]  prev_m;
    logic                     date_ok;

    assign take = !chk_reg.vld || chk_adv;
    assign chk  = chk_reg;

    assign leap    = dic_pkg::leap_year(rec.year);
    assign dim     = dic_pkg::days_in_month(rec.month, leap);
    // month before; january borrows from december
    assign prev_m  = (rec.month == 7'd1) ? 7'(dic_pkg::MONTHS_PER_YEAR) : rec.month - 7'd1;
    assign date_ok = rec.ok && (rec.month >= 7'd1)
                   && (rec.month <= 7'(dic_pkg::MONTHS_PER_YEAR))
                   && (rec.day >= 7'd1) && (rec.day <= {2'b00, dim});

    always_comb
    begin
        chk_next = chk_reg;
        if (rec.vld && take)
        begin
            chk_next.vld      = 1'b1;
            chk_next.which    = rec.which;
            chk_next.day      = rec.day;
            chk_next.month    = rec.month;
            chk_next.year     = rec.year;
            chk_next.ok       = date_ok;
            chk_next.prev_dim = dic_pkg::days_in_month(prev_m, leap);
        end
        else if (chk_adv)
            chk_next.vld = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chk_reg <= '0;
        else
            chk_reg <= chk_next;
    end

endmodule

@@ hdl/dic_diff.sv @@
module dic_diff (
    input  logic          clk,
    input  logic          rst_n,
    input  dic_pkg::chk_t chk,
    output logic          chk_adv,
    dic_out_if.source     result
);

    logic [dic_pkg::DM_W-1:0]     first_day_reg;
    logic [dic_pkg::DM_W-1:0]     first_month_reg;
    logic [dic_pkg::YEAR_W-1:0]   first_year_reg;
    logic                         first_valid_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [dic_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [dic_pkg::YEAR_W-1:0]   years_reg, years_next;
    logic [dic_pkg::MONTHS_W-1:0] months_reg, months_next;
    logic [dic_pkg::DAYS_W-1:0]   days_reg, days_next;

    logic                         out_free;
    logic                         load;
    logic                         later;
    logic [dic_pkg::YEAR_W-1:0]   ry;
    logic [4:0]                   rm_a, rm_b, rm_c;
    logic [6:0]                   rd_a, rd_b;
    logic                         borrow, wrap;

    assign out_free = !out_valid_reg || result.ready;
    assign chk_adv  = chk.vld && (!chk.which || out_free);
    assign load     = chk_adv && chk.which;

    assign later = (first_year_reg > chk.year)
                || (first_year_reg == chk.year && first_month_reg > chk.month)
                || (first_year_reg == chk.year && first_month_reg == chk.month
                    && first_day_reg > chk.day);

    // wrap-around arithmetic; sign bits give the borrows
    assign ry     = chk.year - first_year_reg;
    assign rm_a   = {1'b0, chk.month[3:0]} - {1'b0, first_month_reg[3:0]};
    assign rd_a   = {1'b0, chk.day[5:0]} - {1'b0, first_day_reg[5:0]};
    assign borrow = rd_a[6];
    assign rd_b   = rd_a + (borrow ? {2'b00, chk.prev_dim} : 7'd0);
    assign rm_b   = rm_a - {4'd0, borrow};
    assign wrap   = rm_b[4];
    assign rm_c   = rm_b + (wrap ? 5'(dic_pkg::MONTHS_PER_YEAR) : 5'd0);

    always_comb
    begin
        status_next = dic_pkg::ST_OK;
        years_next  = '0;
        months_next = '0;
        days_next   = '0;
        if (!first_valid_reg)
            status_next = dic_pkg::ST_INIT_BAD;
        else if (!chk.ok)
            status_next = dic_pkg::ST_FINAL_BAD;
        else if (later)
            status_next = dic_pkg::ST_ORDER;
        else
        begin
            years_next  = ry - {13'd0, wrap};
            months_next = rm_c[3:0];
            days_next   = rd_b[5:0];
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_day_reg   <= '0;
            first_month_reg <= '0;
            first_year_reg  <= '0;
            first_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (chk_adv && !chk.which)
            begin
                first_day_reg   <= chk.day;
                first_month_reg <= chk.month;
                first_year_reg  <= chk.year;
                first_valid_reg <= chk.ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            years_reg  <= years_next;
            months_reg <= months_next;
            days_reg   <= days_next;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;
    assign result.years  = years_reg;
    assign result.months = months_reg;
    assign result.days   = $signed(days_reg);

endmodule

@@ hdl/date_interval_calculator.sv @@
// throughput: one char request per cycle unless stalled; three registered stages, parse, check, difference
// input stalls only while a finished result waits at the output and a final date is behind it
// reset: rst_n is asynchronous, active low; parse state, stored initial date and
// pipeline valids clear, so a final date before any initial date reports initial invalid
`include "date_interval_calculator_defines.svh"

module date_interval_calculator (
    input  logic      clk,
    input  logic      rst_n,
    dic_in_if.sink    chars,
    dic_out_if.source result
);

    // parse stage: walks day/month/year fields one char at a time and
    // registers a date record on the last char of each string
    dic_pkg::rec_t rec;
    logic          rec_take;

    // check stage: month range, day against month length (gregorian leap),
    // and the length of the month before, used for a day borrow
    dic_pkg::chk_t chk;
    logic          chk_adv;

    dic_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .take  (rec_take),
        .rec   (rec)
    );

    dic_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec     (rec),
        .take    (rec_take),
        .chk_adv (chk_adv),
        .chk     (chk)
    );

    // difference stage: keeps the latest initial date, compares it with a
    // final date and holds the result until the request is taken
    dic_diff u_diff (
        .clk     (clk),
        .rst_n   (rst_n),
        .chk     (chk),
        .chk_adv (chk_adv),
        .result  (result)
    );

    // non-ok results carry zero fields
    `DIC_ASSERT_SAME(a_zero_fields, result.valid && (result.status != dic_pkg::ST_OK), result.years == '0 && result.months == '0 && result.days == '0, "non-ok result with nonzero fields")

    // input backs up only behind a held result
    `DIC_ASSERT_SAME(a_stall_cause, !chars.ready, result.valid && !result.ready && chk.vld && chk.which, "input stalled without a held result")

    // an accepted last char always leaves a record of the right date kind
    `DIC_ASSERT_NEXT(a_rec_load, chars.valid && chars.ready && chars.last, rec.vld && (rec.which == $past(chars.which_date)), "last char did not load a record")

endmodule
